@@ rtl/clcd_pkg.sv @@
// Shared types and constants for the character LCD write unit.
`default_nettype none

package clcd_pkg;

    // Display memory size and the length of one line in two-line mode.
    localparam int DISPLAY_ENTRIES = 80;
    localparam int LINE_LENGTH     = 40;
    localparam int PATTERN_ENTRIES = 64;
    localparam int DISP_IDX_W      = $clog2(DISPLAY_ENTRIES);
    localparam int PAT_IDX_W       = $clog2(PATTERN_ENTRIES);

    localparam logic [7:0] BLANK_CHAR = 8'h20;

    typedef enum logic [1:0] {
        CMD_INSTR   = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_RD_DISP = 2'd2,
        CMD_RD_PAT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        INS_NONE     = 3'd0,
        INS_FUNC     = 3'd1,
        INS_DISP_CTL = 3'd2,
        INS_CLEAR    = 3'd3,
        INS_HOME     = 3'd4,
        INS_ENTRY    = 3'd5,
        INS_SET_PAT  = 3'd6,
        INS_SET_DISP = 3'd7
    } instr_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic [6:0] read_index;
    } req_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [6:0] display_address;
        logic [5:0] pattern_address;
        logic       data_to_display;
        logic       increment_mode;
        logic       shift_flag;
        logic       two_line;
        logic       eight_bit_bus;
        logic       large_font;
        logic       display_on;
        logic       cursor_on;
        logic       blink_on;
    } rsp_t;

    // Stored mode bits.
    typedef struct packed {
        logic s;
        logic n;
        logic dl;
        logic f;
        logic d;
        logic c;
        logic b;
    } mode_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch the request and read both memories
        logic commit;    // apply the update and load the result register
    } ctl_cmd_t;

    // Instruction decode, first match wins.
    function automatic instr_t decode_instr(input logic [7:0] d);
        instr_t k;
        k = INS_NONE;
        if ((d & 8'he0) == 8'h20)      k = INS_FUNC;
        else if ((d & 8'hf8) == 8'h08) k = INS_DISP_CTL;
        else if (d == 8'h01)           k = INS_CLEAR;
        else if ((d & 8'hfe) == 8'h02) k = INS_HOME;
        else if ((d & 8'hfc) == 8'h04) k = INS_ENTRY;
        else if ((d & 8'hc0) == 8'h40) k = INS_SET_PAT;
        else if ((d & 8'h80) == 8'h80) k = INS_SET_DISP;
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/clcd_ifs.sv @@
// Request and result channel interfaces of the character LCD write unit.
`default_nettype none

interface clcd_req_if;
    import clcd_pkg::*;
    logic valid;
    logic ready;
    req_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface clcd_rsp_if;
    import clcd_pkg::*;
    logic valid;
    logic ready;
    rsp_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ rtl/char_lcd_controller_write_unit.sv @@
// Top level of the character LCD write unit: controller plus datapath.
//
// Usage:
//   req carries one bus request: cmd (instruction write, data write, read of
//   a display entry, read of a pattern entry), the data byte and read_index.
//   rsp returns one result per request: the entry read (zero for writes and
//   out-of-range reads), both address counters and all stored mode bits as
//   they stand after the request.
//   The block takes no new request before the last one is committed: the
//   request is latched and both memories are read in the accept cycle,
//   and the update is applied and the result loaded onto rsp in the
//   execute state, once the result register is free.
//   req.ready is high whenever no request is in execution, also while a
//   finished result still waits on rsp; a request that finds the result
//   register occupied waits in execution until rsp is taken, so a stalled
//   receiver holds back at most one further request.
//   Reset clears the counters, mode bits and the per-entry valid bits, so
//   both memories read as zero at once with no clearing pass. The clear
//   instruction drops the display valid bits and makes unwritten display
//   entries read as a blank.
`default_nettype none

module char_lcd_controller_write_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    clcd_req_if.sink    req,
    clcd_rsp_if.source  rsp
);
    import clcd_pkg::*;

    ctl_cmd_t ctl_cmd;

    // sequence capture and commit against both handshakes
    clcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctl_cmd)
    );

    // hold the register file, memories and result register
    clcd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_item (req.item),
        .cmd      (ctl_cmd),
        .rsp_item (rsp.item)
    );

endmodule

`default_nettype wire

@@ rtl/clcd_ctrl.sv @@
// Controller state machine of the character LCD write unit.
`default_nettype none

module clcd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output clcd_pkg::ctl_cmd_t   cmd
);
    import clcd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_EXEC)
        else $error("capture did not move to execute");

    a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_no_commit_over_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.commit)
        else $error("commit overwrote a waiting result");

endmodule

`default_nettype wire

@@ rtl/clcd_datapath.sv @@
// Datapath of the character LCD write unit: counters, mode bits, memories.
`default_nettype none

module clcd_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire clcd_pkg::req_t    req_item,
    input  wire clcd_pkg::ctl_cmd_t cmd,
    output clcd_pkg::rsp_t         rsp_item
);
    import clcd_pkg::*;

    localparam logic [7:0] DISP_LIMIT = 8'(DISPLAY_ENTRIES);
    localparam logic [7:0] LINE_LIMIT = 8'(LINE_LENGTH);

    // memories
    logic [7:0] disp_mem [DISPLAY_ENTRIES];
    logic [4:0] pat_mem  [PATTERN_ENTRIES];

    // latched request and registered memory reads
    req_t       req_reg;
    logic [7:0] disp_rd_reg;
    logic [4:0] pat_rd_reg;

    // entries written since reset, or for the display since the last clear
    logic [DISPLAY_ENTRIES-1:0] disp_vld_reg, disp_vld_next;
    logic [PATTERN_ENTRIES-1:0] pat_vld_reg, pat_vld_next;
    logic                       fill_blank_reg, fill_blank_next;

    logic [6:0] disp_addr_reg, disp_addr_next;
    logic [5:0] pat_addr_reg, pat_addr_next;
    logic       to_disp_reg, to_disp_next;
    logic       incr_reg, incr_next;
    mode_t      mode_reg, mode_next;

    rsp_t       rsp_reg;

    instr_t                ins;
    logic                  disp_we, pat_we;
    logic [DISP_IDX_W-1:0] disp_wa;
    logic [5:0]            col;
    logic [7:0]            map_idx;
    logic [7:0]            rd_value;
    logic [DISP_IDX_W-1:0] disp_ra;

    assign ins     = decode_instr(req_reg.data);
    assign col     = disp_addr_reg[5:0];
    assign map_idx = mode_reg.n ? ({2'b00, col} + (disp_addr_reg[6] ? LINE_LIMIT : 8'd0))
                                : {1'b0, disp_addr_reg};
    assign disp_wa = map_idx[DISP_IDX_W-1:0];
    assign disp_ra = req_reg.read_index[DISP_IDX_W-1:0];

    always_comb
    begin
        disp_addr_next  = disp_addr_reg;
        pat_addr_next   = pat_addr_reg;
        to_disp_next    = to_disp_reg;
        incr_next       = incr_reg;
        mode_next       = mode_reg;
        disp_vld_next   = disp_vld_reg;
        pat_vld_next    = pat_vld_reg;
        fill_blank_next = fill_blank_reg;
        disp_we         = 1'b0;
        pat_we          = 1'b0;
        rd_value        = 8'd0;
        case (req_reg.cmd)
            CMD_INSTR:
            begin
                case (ins)
                    INS_FUNC:
                    begin
                        mode_next.dl = req_reg.data[4];
                        mode_next.n  = req_reg.data[3];
                        mode_next.f  = req_reg.data[2];
                    end
                    INS_DISP_CTL:
                    begin
                        mode_next.d = req_reg.data[2];
                        mode_next.c = req_reg.data[1];
                        mode_next.b = req_reg.data[0];
                    end
                    INS_CLEAR:
                    begin
                        // every entry now reads as a blank
                        disp_addr_next  = '0;
                        incr_next       = 1'b1;
                        disp_vld_next   = '0;
                        fill_blank_next = 1'b1;
                    end
                    INS_HOME:
                    begin
                        disp_addr_next = '0;
                    end
                    INS_ENTRY:
                    begin
                        incr_next   = req_reg.data[1];
                        mode_next.s = req_reg.data[0];
                    end
                    INS_SET_PAT:
                    begin
                        pat_addr_next = req_reg.data[5:0];
                        to_disp_next  = 1'b0;
                    end
                    INS_SET_DISP:
                    begin
                        disp_addr_next = req_reg.data[6:0];
                        to_disp_next   = 1'b1;
                    end
                    default:
                    begin
                        // cursor shift and null instruction: drop
                    end
                endcase
            end
            CMD_DATA:
            begin
                if (!to_disp_reg)
                begin
                    pat_we                     = 1'b1;
                    pat_vld_next[pat_addr_reg] = 1'b1;
                    pat_addr_next = incr_reg ? pat_addr_reg + 6'd1 : pat_addr_reg - 6'd1;
                end
                else
                begin
                    if (mode_reg.n)
                        disp_we = ({2'b00, col} < LINE_LIMIT) && (map_idx < DISP_LIMIT);
                    else
                        disp_we = map_idx < DISP_LIMIT;
                    if (disp_we)
                        disp_vld_next[disp_wa] = 1'b1;
                    disp_addr_next = incr_reg ? disp_addr_reg + 7'd1 : disp_addr_reg - 7'd1;
                end
            end
            CMD_RD_DISP:
            begin
                if ({1'b0, req_reg.read_index} < DISP_LIMIT)
                begin
                    if (disp_vld_reg[disp_ra])
                        rd_value = disp_rd_reg;
                    else
                        rd_value = fill_blank_reg ? BLANK_CHAR : 8'd0;
                end
            end
            CMD_RD_PAT:
            begin
                if (!req_reg.read_index[6] && pat_vld_reg[req_reg.read_index[5:0]])
                    rd_value = {3'b000, pat_rd_reg};
            end
            default:
            begin
                rd_value = 8'd0;
            end
        endcase
    end

    // memory ports: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            disp_rd_reg <= disp_mem[req_item.read_index[DISP_IDX_W-1:0]];
        if (cmd.commit && disp_we)
            disp_mem[disp_wa] <= req_reg.data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            pat_rd_reg <= pat_mem[req_item.read_index[PAT_IDX_W-1:0]];
        if (cmd.commit && pat_we)
            pat_mem[pat_addr_reg] <= req_reg.data[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req_item;
        if (cmd.commit)
        begin
            rsp_reg.read_value      <= rd_value;
            rsp_reg.display_address <= disp_addr_next;
            rsp_reg.pattern_address <= pat_addr_next;
            rsp_reg.data_to_display <= to_disp_next;
            rsp_reg.increment_mode  <= incr_next;
            rsp_reg.shift_flag      <= mode_next.s;
            rsp_reg.two_line        <= mode_next.n;
            rsp_reg.eight_bit_bus   <= mode_next.dl;
            rsp_reg.large_font      <= mode_next.f;
            rsp_reg.display_on      <= mode_next.d;
            rsp_reg.cursor_on       <= mode_next.c;
            rsp_reg.blink_on        <= mode_next.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_addr_reg  <= '0;
            pat_addr_reg   <= '0;
            to_disp_reg    <= 1'b0;
            incr_reg       <= 1'b0;
            mode_reg       <= '0;
            disp_vld_reg   <= '0;
            pat_vld_reg    <= '0;
            fill_blank_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            disp_addr_reg  <= disp_addr_next;
            pat_addr_reg   <= pat_addr_next;
            to_disp_reg    <= to_disp_next;
            incr_reg       <= incr_next;
            mode_reg       <= mode_next;
            disp_vld_reg   <= disp_vld_next;
            pat_vld_reg    <= pat_vld_next;
            fill_blank_reg <= fill_blank_next;
        end
    end

    assign rsp_item = rsp_reg;

    a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && req_reg.cmd == CMD_INSTR && ins == INS_CLEAR)
        |=> (disp_addr_reg == 7'd0) && incr_reg && fill_blank_reg && (disp_vld_reg == '0))
        else $error("clear left state behind");

    a_read_keeps_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (req_reg.cmd == CMD_RD_DISP || req_reg.cmd == CMD_RD_PAT))
        |=> $stable(disp_addr_reg) && $stable(pat_addr_reg))
        else $error("read moved an address counter");

    a_one_memory_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(disp_we && pat_we))
        else $error("both memories written by one request");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the character LCD write unit: directed and random requests.
`default_nettype none

module tb_top;
    import clcd_pkg::*;

    // Run limits: the watchdog cycle limit and the idle tail after the final drain.
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    // Instruction opcodes; low bits carry the operands.
    localparam logic [7:0] OP_NULL     = 8'h00;
    localparam logic [7:0] OP_CLEAR    = 8'h01;
    localparam logic [7:0] OP_HOME     = 8'h02;
    localparam logic [7:0] OP_ENTRY    = 8'h04;
    localparam logic [7:0] OP_DISP_CTL = 8'h08;
    localparam logic [7:0] OP_SHIFT    = 8'h10;
    localparam logic [7:0] OP_FUNC     = 8'h20;
    localparam logic [7:0] OP_SET_PAT  = 8'h40;
    localparam logic [7:0] OP_SET_DISP = 8'h80;

    logic clk;
    logic rst_n;

    clcd_req_if req_ch ();
    clcd_rsp_if rsp_ch ();

    char_lcd_controller_write_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the controller state, advanced once per accepted request.
    logic [7:0] shadow_disp [DISPLAY_ENTRIES];
    logic [4:0] shadow_pat  [PATTERN_ENTRIES];
    logic [6:0] shadow_daddr;
    logic [5:0] shadow_paddr;
    logic       shadow_to_disp;
    logic       shadow_inc;
    mode_t      shadow_mode;

    // Status words still owed by the block, oldest first.
    rsp_t lcd_status_q [$];

    int req_gap_pct;
    int rsp_stall_pct;
    int requests_sent;
    int results_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one request to the shadow state and return the status it must produce.
    function automatic rsp_t lcd_access(req_t r);
        rsp_t       o;
        logic [7:0] d;
        logic [5:0] col;
        int         idx;
        o = '0;
        d = r.data;
        case (r.cmd)
            CMD_INSTR:
            begin
                // First matching class wins; cursor shift and null fall through.
                if ((d & 8'he0) == OP_FUNC)
                begin
                    shadow_mode.dl = d[4];
                    shadow_mode.n  = d[3];
                    shadow_mode.f  = d[2];
                end
                else if ((d & 8'hf8) == OP_DISP_CTL)
                begin
                    shadow_mode.d = d[2];
                    shadow_mode.c = d[1];
                    shadow_mode.b = d[0];
                end
                else if (d == OP_CLEAR)
                begin
                    shadow_daddr = '0;
                    shadow_inc   = 1'b1;
                    foreach (shadow_disp[i]) shadow_disp[i] = BLANK_CHAR;
                end
                else if ((d & 8'hfe) == OP_HOME)
                begin
                    shadow_daddr = '0;
                end
                else if ((d & 8'hfc) == OP_ENTRY)
                begin
                    shadow_inc    = d[1];
                    shadow_mode.s = d[0];
                end
                else if ((d & 8'hc0) == OP_SET_PAT)
                begin
                    shadow_paddr   = d[5:0];
                    shadow_to_disp = 1'b0;
                end
                else if ((d & OP_SET_DISP) == OP_SET_DISP)
                begin
                    shadow_daddr   = d[6:0];
                    shadow_to_disp = 1'b1;
                end
            end
            CMD_DATA:
            begin
                if (!shadow_to_disp)
                begin
                    shadow_pat[shadow_paddr] = d[4:0];
                    shadow_paddr = shadow_inc ? shadow_paddr + 6'd1 : shadow_paddr - 6'd1;
                end
                else
                begin
                    // Two-line mode maps bit 6 to the row; columns past the line drop.
                    if (shadow_mode.n)
                    begin
                        col = shadow_daddr[5:0];
                        idx = col + (shadow_daddr[6] ? LINE_LENGTH : 0);
                        if (col < LINE_LENGTH && idx < DISPLAY_ENTRIES)
                            shadow_disp[idx] = d;
                    end
                    else if (shadow_daddr < DISPLAY_ENTRIES)
                    begin
                        shadow_disp[shadow_daddr] = d;
                    end
                    // The counter steps even when the write was dropped.
                    shadow_daddr = shadow_inc ? shadow_daddr + 7'd1 : shadow_daddr - 7'd1;
                end
            end
            CMD_RD_DISP:
            begin
                if (r.read_index < DISPLAY_ENTRIES)
                    o.read_value = shadow_disp[r.read_index];
            end
            default:
            begin
                if (r.read_index < PATTERN_ENTRIES)
                    o.read_value = {3'b000, shadow_pat[r.read_index[5:0]]};
            end
        endcase
        o.display_address = shadow_daddr;
        o.pattern_address = shadow_paddr;
        o.data_to_display = shadow_to_disp;
        o.increment_mode  = shadow_inc;
        o.shift_flag      = shadow_mode.s;
        o.two_line        = shadow_mode.n;
        o.eight_bit_bus   = shadow_mode.dl;
        o.large_font      = shadow_mode.f;
        o.display_on      = shadow_mode.d;
        o.cursor_on       = shadow_mode.c;
        o.blink_on        = shadow_mode.b;
        return o;
    endfunction

    // Offer one request, idling first at random, and hold it until taken.
    task automatic issue(cmd_t c, logic [7:0] d, logic [6:0] idx);
        req_t r;
        r.cmd        = c;
        r.data       = d;
        r.read_index = idx;
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        lcd_status_q.push_back(lcd_access(r));
        requests_sent++;
    endtask

    // Drop valid and hold off until every owed status has come back.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (lcd_status_q.size() != 0);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_status(rsp_t got);
        rsp_t want;
        if (lcd_status_q.size() == 0)
        begin
            $error("status word with no request outstanding: 0x%0h", got);
            mismatches++;
        end
        else
        begin
            want = lcd_status_q.pop_front();
            results_checked++;
            check_field("read_value", want.read_value, got.read_value);
            check_field("display_address", want.display_address, got.display_address);
            check_field("pattern_address", want.pattern_address, got.pattern_address);
            check_field("data_to_display", want.data_to_display, got.data_to_display);
            check_field("increment_mode", want.increment_mode, got.increment_mode);
            check_field("shift_flag", want.shift_flag, got.shift_flag);
            check_field("two_line", want.two_line, got.two_line);
            check_field("eight_bit_bus", want.eight_bit_bus, got.eight_bit_bus);
            check_field("large_font", want.large_font, got.large_font);
            check_field("display_on", want.display_on, got.display_on);
            check_field("cursor_on", want.cursor_on, got.cursor_on);
            check_field("blink_on", want.blink_on, got.blink_on);
        end
    endtask

    // Mostly in-range indices, with a share reaching the full 7-bit field.
    function automatic logic [6:0] rand_index();
        if ($urandom_range(3) == 0)
            return 7'($urandom_range(127));
        return 7'($urandom_range(DISPLAY_ENTRIES - 1));
    endfunction

    // Receiver: check each taken status word, then stall at random.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_status(rsp_ch.item);
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Watchdog: end a run that has stopped making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d requests owed",
                     cycle_count, lcd_status_q.size());
            $display("[char_lcd_controller_write_unit] ERROR");
            $finish;
        end
    end

    // Display entry 0 and all counters must read as zero straight after reset; the pattern read is out of range.
    task automatic test_reset_state();
        issue(CMD_RD_DISP, 8'h00, 7'd0);
        issue(CMD_RD_PAT, 8'hff, 7'd127);
    endtask

    // Every instruction class; function set, display control and entry mode with operand bits at both extremes.
    task automatic test_instruction_set();
        issue(CMD_INSTR, OP_FUNC | 8'h1f, 7'd0);
        issue(CMD_INSTR, OP_DISP_CTL | 8'h07, 7'd0);
        issue(CMD_INSTR, OP_ENTRY | 8'h03, 7'd0);
        // Cursor shift and the null instruction must leave everything alone.
        issue(CMD_INSTR, OP_SHIFT | 8'h0f, 7'd0);
        issue(CMD_INSTR, OP_NULL, 7'd127);
        issue(CMD_INSTR, OP_SET_DISP | 8'h7f, 7'd0);
        // Home ignores its low bit.
        issue(CMD_INSTR, OP_HOME | 8'h01, 7'd0);
        issue(CMD_INSTR, OP_SET_PAT | 8'h3f, 7'd0);
        issue(CMD_INSTR, OP_CLEAR, 7'd0);
        issue(CMD_INSTR, OP_DISP_CTL, 7'd0);
        issue(CMD_INSTR, OP_ENTRY, 7'd0);
        issue(CMD_INSTR, OP_FUNC, 7'd0);
    endtask

    // Pattern writes with wrap, then one-line and two-line display writes with drops.
    task automatic test_write_paths();
        // Pattern target at 63, decrementing: store masks to five bits.
        issue(CMD_DATA, 8'hff, 7'd0);
        issue(CMD_INSTR, OP_SET_PAT, 7'd0);
        issue(CMD_DATA, 8'h15, 7'd0);
        issue(CMD_RD_PAT, 8'h00, 7'd63);
        // One-line: last entry lands, the next one past the end drops.
        issue(CMD_INSTR, OP_SET_DISP | 8'(DISPLAY_ENTRIES - 1), 7'd0);
        issue(CMD_INSTR, OP_ENTRY | 8'h02, 7'd0);
        issue(CMD_DATA, 8'haa, 7'd0);
        issue(CMD_DATA, 8'h55, 7'd0);
        // Two-line: last column of the second row, then a column past the line.
        issue(CMD_INSTR, OP_FUNC | 8'h08, 7'd0);
        issue(CMD_INSTR, OP_SET_DISP | 8'h40 | 8'(LINE_LENGTH - 1), 7'd0);
        issue(CMD_DATA, 8'h5a, 7'd0);
        issue(CMD_DATA, 8'h33, 7'd0);
        issue(CMD_RD_DISP, 8'h00, 7'(DISPLAY_ENTRIES - 1));
        // Entry untouched since the clear must read as a blank.
        issue(CMD_RD_DISP, 8'h00, 7'(DISPLAY_ENTRIES - 2));
    endtask

    // Random traffic under one idle mix; drains once halfway through.
    task automatic test_random_traffic(int gap_pct, int stall_pct, int count);
        int         target;
        int         sel;
        bit         paused;
        logic [7:0] op;
        req_gap_pct   = gap_pct;
        rsp_stall_pct = stall_pct;
        target        = requests_sent + count;
        paused        = 1'b0;
        while (requests_sent < target)
        begin
            if (!paused && requests_sent >= target - count / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 25)
            begin
                // Set an address, then a run of data writes into that memory.
                if ($urandom_range(1))
                    op = OP_SET_PAT | 8'($urandom_range(63));
                else
                    op = OP_SET_DISP | 8'($urandom_range(127));
                issue(CMD_INSTR, op, rand_index());
                repeat ($urandom_range(1, 6))
                    issue(CMD_DATA, 8'($urandom_range(255)), rand_index());
            end
            else if (sel < 45)
            begin
                case ($urandom_range(9))
                    0: op = OP_FUNC | 8'($urandom_range(31));
                    1: op = OP_DISP_CTL | 8'($urandom_range(7));
                    2: op = OP_CLEAR;
                    3: op = OP_HOME | 8'($urandom_range(1));
                    4: op = OP_ENTRY | 8'($urandom_range(3));
                    5: op = OP_SET_PAT | 8'($urandom_range(63));
                    6: op = OP_SET_DISP | 8'($urandom_range(127));
                    7: op = OP_SHIFT | 8'($urandom_range(15));
                    8: op = OP_NULL;
                    default: op = 8'($urandom_range(255));
                endcase
                issue(CMD_INSTR, op, rand_index());
            end
            else if (sel < 65)
            begin
                issue(CMD_DATA, 8'($urandom_range(255)), rand_index());
            end
            else if (sel < 85)
            begin
                issue(CMD_RD_DISP, 8'($urandom_range(255)), rand_index());
            end
            else
            begin
                issue(CMD_RD_PAT, 8'($urandom_range(255)), rand_index());
            end
        end
    endtask

    initial
    begin
        // Drive the request channel and reset to a known level before the first edge.
        req_ch.valid <= 1'b0;
        req_ch.item  <= '0;
        rst_n        <= 1'b0;
        foreach (shadow_disp[i]) shadow_disp[i] = '0;
        foreach (shadow_pat[i]) shadow_pat[i] = '0;
        shadow_daddr    = '0;
        shadow_paddr    = '0;
        shadow_to_disp  = 1'b0;
        shadow_inc      = 1'b0;
        shadow_mode     = '0;
        requests_sent   = 0;
        req_gap_pct     = 36;
        rsp_stall_pct   = 60;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_instruction_set();
        test_write_paths();
        test_random_traffic(36, 60, 200);
        test_random_traffic(60, 36, 200);
        test_random_traffic(0, 0, 200);

        // Let the last status words arrive, then watch for strays.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered reset reads, all instruction classes, one- and two-line writes");
        $display("with drops and wrap: %0d requests sent, %0d status words checked",
                 requests_sent, results_checked);
        if (mismatches == 0)
            $display("[char_lcd_controller_write_unit] OK");
        else
            $display("[char_lcd_controller_write_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
